FILE: hdl/assert_macros.svh
// Assertion helpers; each one samples on clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/ffcu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffcu_pkg;

    localparam int DEF_GRID_WIDTH  = 64;
    localparam int DEF_GRID_HEIGHT = 32;

    localparam int THR_W     = 25;
    localparam int DRAW_W    = 24;
    localparam int VAL_W     = 3;
    localparam int COLOR_W   = 8;
    localparam int COL_OUT_W = 6;
    localparam int ROW_OUT_W = 5;
    localparam int TINT_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 4;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 40;

    localparam logic [THR_W-1:0] SEED_THR_RST   = 25'd6710886;
    localparam logic [THR_W-1:0] GROW_THR_RST   = 25'd134218;
    localparam logic [THR_W-1:0] STRIKE_THR_RST = 25'd336;

    localparam logic ACT_SEED   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    localparam logic [VAL_W-1:0] VAL_EMPTY    = 3'd0;
    localparam logic [VAL_W-1:0] VAL_TREE     = 3'd1;
    localparam logic [VAL_W-1:0] VAL_BURN_MIN = 3'd2;
    localparam logic [VAL_W-1:0] VAL_IGNITE   = 3'd6;

    // step 0 reads the cell itself, steps 1..8 its neighbors, step 9 drains
    localparam logic [STEP_W-1:0] STEP_CELL  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd9;

    localparam logic [TINT_W-1:0] TINT_COL_STEP = 6'd7;
    localparam logic [TINT_W-1:0] TINT_ROW_STEP = 6'd13;
    localparam logic [TINT_W-1:0] TINT_MOD      = 6'd40;

    localparam logic [COLOR_W-1:0] EMPTY_R = 8'd12;
    localparam logic [COLOR_W-1:0] EMPTY_G = 8'd8;
    localparam logic [COLOR_W-1:0] EMPTY_B = 8'd4;
    localparam logic [COLOR_W-1:0] TREE_R  = 8'd10;
    localparam logic [COLOR_W-1:0] TREE_G  = 8'd90;
    localparam logic [COLOR_W-1:0] TREE_B  = 8'd20;
    localparam logic [COLOR_W-1:0] FIRE_R  = 8'd255;
    localparam logic [COLOR_W:0]   FIRE_G0 = 9'd90;
    localparam logic [COLOR_W:0]   FIRE_GS = 9'd30;
    localparam logic [COLOR_W:0]   G_MAX   = 9'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED   = 2'd0,
        REG_GROW   = 2'd1,
        REG_STRIKE = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OFS_MINUS,
        OFS_ZERO,
        OFS_PLUS
    } offset_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] cell_column;
        logic [ROW_OUT_W-1:0] cell_row;
        logic [VAL_W-1:0]     cell_value;
        logic [TINT_W-1:0]    tint;
        logic                 frame_done;
    } result_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    function automatic offset_t probe_dx(input logic [STEP_W-1:0] step);
        offset_t o;
        unique case (step)
            4'd1, 4'd4, 4'd6: o = OFS_MINUS;
            4'd3, 4'd5, 4'd8: o = OFS_PLUS;
            default:          o = OFS_ZERO;
        endcase
        return o;
    endfunction

    function automatic offset_t probe_dy(input logic [STEP_W-1:0] step);
        offset_t o;
        unique case (step)
            4'd1, 4'd2, 4'd3: o = OFS_MINUS;
            4'd6, 4'd7, 4'd8: o = OFS_PLUS;
            default:          o = OFS_ZERO;
        endcase
        return o;
    endfunction

    function automatic rgb_t cell_rgb(input logic [VAL_W-1:0] value,
                                      input logic [TINT_W-1:0] tint);
        rgb_t             c;
        logic [VAL_W-1:0] age;
        logic [COLOR_W:0] g;
        age = value - VAL_TREE;
        g   = FIRE_G0 + FIRE_GS * (COLOR_W+1)'(age);
        priority if (value == VAL_EMPTY)
        begin
            c.red   = EMPTY_R;
            c.green = EMPTY_G;
            c.blue  = EMPTY_B;
        end
        else if (value == VAL_TREE)
        begin
            c.red   = TREE_R;
            c.green = TREE_G + COLOR_W'(tint);
            c.blue  = TREE_B;
        end
        else
        begin
            c.red   = FIRE_R;
            c.green = (g > G_MAX) ? G_MAX[COLOR_W-1:0] : g[COLOR_W-1:0];
            c.blue  = COLOR_W'({age, 3'b000});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ffcu_cell_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ffcu_cell_mem #(
    parameter int MEM_AW = 12
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [MEM_AW-1:0]         waddr,
    input  logic [ffcu_pkg::VAL_W-1:0] wdata,
    input  logic [MEM_AW-1:0]         raddr,
    output logic [ffcu_pkg::VAL_W-1:0] rdata
);
    import ffcu_pkg::*;

    logic [VAL_W-1:0] mem [0:(1 << MEM_AW)-1];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/ffcu_raster.sv
`timescale 1ns / 1ps
`default_nettype none

module ffcu_raster #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    output logic [$clog2(GRID_WIDTH)-1:0]  col,
    output logic [$clog2(GRID_HEIGHT)-1:0] row,
    output logic [ffcu_pkg::TINT_W-1:0]    tint,
    output logic                          last
);
    import ffcu_pkg::*;

    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int ROW_W = $clog2(GRID_HEIGHT);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_HEIGHT - 1);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [TINT_W-1:0] tint_reg, tint_next;
    logic [TINT_W-1:0] row_tint_reg, row_tint_next;
    logic [TINT_W-1:0] col_sum, row_sum;

    // tint is (7*col + 13*row) mod 40, kept up to date one step at a time
    always_comb
    begin
        col_sum       = tint_reg + TINT_COL_STEP;
        row_sum       = row_tint_reg + TINT_ROW_STEP;
        col_next      = col_reg;
        row_next      = row_reg;
        tint_next     = tint_reg;
        row_tint_next = row_tint_reg;
        if (advance)
        begin
            if (col_reg == COL_LAST)
            begin
                col_next = '0;
                if (row_reg == ROW_LAST)
                begin
                    row_next      = '0;
                    row_tint_next = '0;
                end
                else
                begin
                    row_next      = row_reg + ROW_W'(1);
                    row_tint_next = (row_sum >= TINT_MOD) ? row_sum - TINT_MOD : row_sum;
                end
                tint_next = row_tint_next;
            end
            else
            begin
                col_next  = col_reg + COL_W'(1);
                tint_next = (col_sum >= TINT_MOD) ? col_sum - TINT_MOD : col_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            tint_reg     <= '0;
            row_tint_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            tint_reg     <= tint_next;
            row_tint_reg <= row_tint_next;
        end
    end

    assign col  = col_reg;
    assign row  = row_reg;
    assign tint = tint_reg;
    assign last = (col_reg == COL_LAST) && (row_reg == ROW_LAST);

endmodule

`default_nettype wire

FILE: hdl/ffcu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffcu_ctrl #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic                                   action,
    input  logic [ffcu_pkg::DRAW_W-1:0]            draw,
    input  logic [ffcu_pkg::THR_W-1:0]             seed_thr,
    input  logic [ffcu_pkg::THR_W-1:0]             grow_thr,
    input  logic [ffcu_pkg::THR_W-1:0]             strike_thr,
    input  logic [$clog2(GRID_WIDTH)-1:0]           col,
    input  logic [$clog2(GRID_HEIGHT)-1:0]          row,
    input  logic [ffcu_pkg::TINT_W-1:0]             tint,
    input  logic                                   last,
    input  logic                                   out_free,
    output logic                                   mem_we,
    output logic [$clog2(GRID_WIDTH*GRID_HEIGHT):0] mem_waddr,
    output logic [ffcu_pkg::VAL_W-1:0]             mem_wdata,
    output logic [$clog2(GRID_WIDTH*GRID_HEIGHT):0] mem_raddr,
    input  logic [ffcu_pkg::VAL_W-1:0]             mem_rdata,
    output logic                                   advance,
    output logic                                   res_valid,
    output ffcu_pkg::result_t                      res
);
    import ffcu_pkg::*;

    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int LIN_W  = $clog2(GRID_WIDTH * GRID_HEIGHT);
    localparam int MEM_AW = LIN_W + 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_HEIGHT - 1);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic                bank_reg;
    logic [MEM_AW-1:0]   clr_reg;

    logic [LIN_W-1:0]    lin_reg;
    logic [DRAW_W-1:0]   draw_reg;
    logic                action_reg;
    logic [VAL_W-1:0]    cur_reg;
    logic                burn_reg;
    logic                probe_ok_reg;

    offset_t             ox, oy;
    logic [COL_W-1:0]    nx;
    logic [ROW_W-1:0]    ny;
    logic                in_grid;
    logic [LIN_W-1:0]    probe_lin;
    logic [VAL_W-1:0]    new_val;
    logic [THR_W-1:0]    draw_ext;
    logic                accept;
    logic [COL_W+COL_OUT_W-1:0] col_wide;
    logic [ROW_W+ROW_OUT_W-1:0] row_wide;

    // neighbor address for the current probe step, with its in-grid flag
    always_comb
    begin
        ox      = probe_dx(step_reg);
        oy      = probe_dy(step_reg);
        nx      = col;
        ny      = row;
        in_grid = 1'b1;
        unique case (ox)
            OFS_MINUS:
            begin
                nx = col - COL_W'(1);
                if (col == '0) in_grid = 1'b0;
            end
            OFS_PLUS:
            begin
                nx = col + COL_W'(1);
                if (col == COL_LAST) in_grid = 1'b0;
            end
            default: ;
        endcase
        unique case (oy)
            OFS_MINUS:
            begin
                ny = row - ROW_W'(1);
                if (row == '0) in_grid = 1'b0;
            end
            OFS_PLUS:
            begin
                ny = row + ROW_W'(1);
                if (row == ROW_LAST) in_grid = 1'b0;
            end
            default: ;
        endcase
        probe_lin = LIN_W'(ny) * LIN_W'(GRID_WIDTH) + LIN_W'(nx);
    end

    always_comb
    begin
        draw_ext = THR_W'(draw_reg);
        priority if (action_reg == ACT_SEED)
            new_val = (draw_ext < seed_thr) ? VAL_TREE : VAL_EMPTY;
        else if (cur_reg == VAL_EMPTY)
            new_val = (draw_ext < grow_thr) ? VAL_TREE : VAL_EMPTY;
        else if (cur_reg == VAL_TREE)
            new_val = (burn_reg || (draw_ext < strike_thr)) ? VAL_IGNITE : VAL_TREE;
        else if (cur_reg > VAL_BURN_MIN)
            new_val = cur_reg - VAL_TREE;
        else
            new_val = VAL_EMPTY;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid) state_next = (action == ACT_UPDATE) ? ST_SCAN : ST_FINISH;
            ST_SCAN:
                if (step_reg == STEP_LAST) state_next = ST_FINISH;
            ST_FINISH:
                if (out_free) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_FINISH) && out_free;
        advance   = res_valid;
        mem_raddr = {bank_reg, probe_lin};
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = VAL_EMPTY;
        end
        else
        begin
            mem_we    = res_valid;
            // seeds go to the current bank, updates to the other one
            mem_waddr = {bank_reg ^ action_reg, lin_reg};
            mem_wdata = new_val;
        end
    end

    assign accept   = s_tvalid && s_tready;
    assign col_wide = (COL_W+COL_OUT_W)'(col);
    assign row_wide = (ROW_W+ROW_OUT_W)'(row);

    always_comb
    begin
        res.cell_column = col_wide[COL_OUT_W-1:0];
        res.cell_row    = row_wide[ROW_OUT_W-1:0];
        res.cell_value  = new_val;
        res.tint        = tint;
        res.frame_done  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= STEP_CELL;
            bank_reg  <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + MEM_AW'(1);
            end
            if (state_reg == ST_SCAN)
            begin
                step_reg <= (step_reg == STEP_LAST) ? STEP_CELL : step_reg + STEP_W'(1);
            end
            if (res_valid && last && (action_reg == ACT_UPDATE))
            begin
                bank_reg <= ~bank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            draw_reg   <= draw;
            action_reg <= action;
            lin_reg    <= probe_lin;
            burn_reg   <= 1'b0;
        end
        if (state_reg == ST_SCAN)
        begin
            probe_ok_reg <= in_grid;
            // read data trails the probe address by one step
            if (step_reg == STEP_FIRST)
            begin
                cur_reg <= mem_rdata;
            end
            else if ((step_reg > STEP_FIRST) && probe_ok_reg && (mem_rdata >= VAL_BURN_MIN))
            begin
                burn_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/forest_fire_cell_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Signals                                 Direction  Carries
// s_*       s_tvalid s_tready s_tdata s_tuser       in         one cell request per item
// m_*       m_tvalid m_tready m_tdata m_tlast       out        cell state and color
// cfg_*     cfg_valid cfg_ready cfg_index cfg_data  in         threshold register writes
//
// A seed request goes straight to write-back; for an update request one memory read port
// visits the cell and its eight neighbors in turn, then a drain step and a write-back follow.
// After reset all 2 * 2**clog2(GRID_WIDTH*GRID_HEIGHT) entries of the cell memory (4096 at the
// defaults) are swept to zero, one entry a cycle; s_tready stays low meanwhile.
// Configuration writes are always taken. A result waits in the output register while
// m_tready is low; the next request is taken meanwhile and holds in write-back.

`include "assert_macros.svh"

module forest_fire_cell_update_unit #(
    parameter int GRID_WIDTH  = ffcu_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = ffcu_pkg::DEF_GRID_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ffcu_pkg::S_DATA_W-1:0]     s_tdata,   // random_draw[23:0]
    input  logic [0:0]                        s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cell_column[5:0], cell_row[10:6], cell_value[13:11], red[21:14],
    // green[29:22], blue[37:30], zero[39:38]
    output logic [ffcu_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast,   // frame_done
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffcu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffcu_pkg::THR_W-1:0]        cfg_data
);
    import ffcu_pkg::*;

    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int MEM_AW = $clog2(GRID_WIDTH * GRID_HEIGHT) + 1;

    logic [THR_W-1:0]    seed_thr_reg, grow_thr_reg, strike_thr_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [TINT_W-1:0]   tint;
    logic                last;
    logic                advance;
    logic                out_free;
    logic                res_valid;
    result_t             res;
    rgb_t                rgb;

    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
    logic [VAL_W-1:0]    mem_wdata, mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_thr_reg   <= SEED_THR_RST;
            grow_thr_reg   <= GROW_THR_RST;
            strike_thr_reg <= STRIKE_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SEED:   seed_thr_reg   <= cfg_data;
                REG_GROW:   grow_thr_reg   <= cfg_data;
                REG_STRIKE: strike_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ffcu_raster #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT)
    ) u_raster (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .col    (col),
        .row    (row),
        .tint   (tint),
        .last   (last)
    );

    ffcu_cell_mem #(
        .MEM_AW(MEM_AW)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    ffcu_ctrl #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (s_tuser[0]),
        .draw      (s_tdata[DRAW_W-1:0]),
        .seed_thr  (seed_thr_reg),
        .grow_thr  (grow_thr_reg),
        .strike_thr(strike_thr_reg),
        .col       (col),
        .row       (row),
        .tint      (tint),
        .last      (last),
        .out_free  (out_free),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign rgb      = cell_rgb(res.cell_value, res.tint);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_data_reg <= {2'b00, rgb.blue, rgb.green, rgb.red,
                           res.cell_value, res.cell_row, res.cell_column};
            m_last_reg <= res.frame_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `ASSERT_IMPLIES(a_load_needs_room, res_valid, !m_valid_reg || m_tready, "result overwrote output")
    `ASSERT_NEXT(a_wrap_after_last, res_valid && res.frame_done, (col == '0) && (row == '0), "raster did not wrap")

endmodule

`default_nettype wire
